// File: rtl/route_feasibility_checker_assert.svh
// assertion macros for the route feasibility checker
// clocked on i_clk, switched off while i_rst_n is low
`ifndef ROUTE_FEASIBILITY_CHECKER_ASSERT_SVH
`define ROUTE_FEASIBILITY_CHECKER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

    // fixed field widths
    localparam int NODE_W      = 8;
    localparam int IN_COORD_W  = 16;
    localparam int DEMAND_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STATUS_W    = 2;
    localparam int TOUR_W      = 48;
    localparam int LOAD_W      = 18;
    localparam int RATE_FRAC   = 8;

    // item operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENERGY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSUMPTION_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_NODE       = 2'd3;

    localparam logic [CFG_W-1:0] RATE_RESET = 16'd256;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_WRITE,
        S_RESTART,
        S_RD_PREV,
        S_RD_CUR,
        S_DIFF,
        S_SQ_X,
        S_SQ_Y,
        S_ROOT,
        S_ENERGY,
        S_UPDATE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/rfc_slot_reduce.sv
`default_nettype none

// node index modulo table depth, one index bit per cycle
module rfc_slot_reduce #(
    parameter int NODE_COUNT = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [rfc_pkg::NODE_W-1:0]             i_node,
    output logic                                   o_done,
    output logic [$clog2(NODE_COUNT)-1:0]          o_slot
);
    import rfc_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NODE_W - 1);
    localparam logic [IDX_W:0]   DEPTH = (IDX_W + 1)'(NODE_COUNT);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NODE_W-1:0] r_bits;
    logic [IDX_W-1:0]  r_rem;
    logic [IDX_W:0]    trial;
    logic [IDX_W-1:0]  n_rem;

    // shift in the next index bit and take off the depth once if it fits
    always_comb begin
        trial = {r_rem, r_bits[NODE_W-1]};
        if (trial >= DEPTH) begin
            n_rem = IDX_W'(trial - DEPTH);
        end else begin
            n_rem = trial[IDX_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bits <= i_node;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_bits <= {r_bits[NODE_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;

endmodule

`default_nettype wire

// File: rtl/rfc_serial_mult.sv
`default_nettype none

// shift-add multiplier, one multiplier bit per cycle
module rfc_serial_mult #(
    parameter int A_W = 25,
    parameter int B_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_done,
    output logic [A_W+B_W-1:0]   o_product
);
    import rfc_pkg::*;

    localparam int CNT_W = $clog2(B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [A_W:0]     sum;

    // partial sum for the current multiplier bit
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shifts right, low half takes the finished bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[A_W:1];
            r_lo <= {sum[0], r_lo[B_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

`default_nettype wire

// File: rtl/rfc_serial_root.sv
`default_nettype none

// restoring square root, two radicand bits in and one root bit out per cycle
module rfc_serial_root #(
    parameter int PAIRS = 17,
    parameter int FRAC  = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*PAIRS-1:0]        i_radicand,
    output logic                      o_done,
    output logic [PAIRS+FRAC-1:0]     o_root
);
    import rfc_pkg::*;

    localparam int RAD_W  = 2 * PAIRS;
    localparam int ROOT_W = PAIRS + FRAC;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    // one digit: bring down two bits, try subtracting 4*root+1
    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // radicand drains from the top, zeros follow for the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: rtl/route_feasibility_checker.sv
// Electric vehicle route checker. Load items write a node table entry (coordinates,
// demand, station flag); route items walk a route: a route_start item restores load
// and battery and clears the tour, every other route item is a hop from the previous
// node whose Euclidean distance (FRACTION_BITS fraction bits, truncated) is added to
// the saturating tour length and drives the load and energy checks. A violation sets
// a sticky status and fault node until the next start. Every item gives exactly one
// result. One item is worked at a time; the output register lets the next item in
// while a result still waits. The time of load and start items is set mostly by the
// bit-serial reduction of the node index to a table slot. The time of a hop is set
// by the shift-add multiplier used for both squares and the energy product and by
// the root unit, which yields one root bit per cycle. The next item can be taken in
// the cycle after the result is registered. The node table holds garbage after
// reset; entries must be loaded before a route uses them.
`default_nettype none

`include "route_feasibility_checker_assert.svh"

module route_feasibility_checker #(
    parameter int NODE_COUNT    = 256,
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item in
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_operation,
    input  logic [rfc_pkg::NODE_W-1:0]           i_node_index,
    input  logic [rfc_pkg::IN_COORD_W-1:0]       i_coord_x,
    input  logic [rfc_pkg::IN_COORD_W-1:0]       i_coord_y,
    input  logic [rfc_pkg::DEMAND_W-1:0]         i_node_demand,
    input  logic                                 i_station_flag,
    input  logic                                 i_route_start,
    input  logic                                 i_route_end,
    // item out
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [rfc_pkg::STATUS_W-1:0]         o_status,
    output logic [rfc_pkg::TOUR_W-1:0]           o_route_length,
    output logic [rfc_pkg::NODE_W-1:0]           o_fault_node,
    output logic                                 o_route_done,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]            i_cfg_data
);
    import rfc_pkg::*;

    localparam int IDX_W    = $clog2(NODE_COUNT);
    localparam int CB       = COORD_BITS;
    localparam int DIST_W   = COORD_BITS + 1 + FRACTION_BITS;
    localparam int MB_W     = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int PROD_W   = DIST_W + MB_W;
    localparam int USED_W   = PROD_W - RATE_FRAC;
    localparam int SQ_W     = 2 * COORD_BITS + 1;
    localparam int RAD_W    = 2 * COORD_BITS + 2;
    localparam int ENERGY_W = CFG_W + FRACTION_BITS;
    localparam int ENTRY_W  = 2 * COORD_BITS + DEMAND_W + 1;

    // sequencer and captured item
    t_state              r_state;
    t_state              n_state;
    logic                r_op;
    logic [NODE_W-1:0]   r_node;
    logic [CB-1:0]       r_x;
    logic [CB-1:0]       r_y;
    logic [DEMAND_W-1:0] r_demand_in;
    logic                r_station_in;
    logic                r_start;
    logic                r_end;
    logic [IDX_W-1:0]    r_slot;

    // route state
    logic [IDX_W-1:0]    r_prev_slot;
    logic [LOAD_W-1:0]   r_load;
    logic [ENERGY_W-1:0] r_energy;
    logic [TOUR_W-1:0]   r_tour;
    logic [STATUS_W-1:0] r_err;
    logic [NODE_W-1:0]   r_err_node;

    // configuration
    logic [CFG_W-1:0]    r_load_cap;
    logic [CFG_W-1:0]    r_batt_cap;
    logic [CFG_W-1:0]    r_rate;
    logic [NODE_W-1:0]   r_depot;

    // hop working registers
    logic [CB-1:0]       r_prev_x;
    logic [CB-1:0]       r_prev_y;
    logic [CB-1:0]       r_dy;
    logic [2*CB-1:0]     r_sq;
    logic [DEMAND_W-1:0] r_cur_demand;
    logic                r_cur_station;
    logic [DIST_W-1:0]   r_dist;
    logic [USED_W-1:0]   r_used;

    // node table
    logic [ENTRY_W-1:0]  r_table [NODE_COUNT];
    logic [ENTRY_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]    rd_addr;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TOUR_W-1:0]   r_out_tour;
    logic [NODE_W-1:0]   r_out_fault;
    logic                r_out_done;

    // unit handshakes
    logic                in_take;
    logic                emit_ok;
    logic                slot_done;
    logic [IDX_W-1:0]    slot_val;
    logic                mul_start;
    logic [DIST_W-1:0]   mul_a;
    logic [MB_W-1:0]     mul_b;
    logic                mul_done;
    logic [PROD_W-1:0]   mul_prod;
    logic                root_start;
    logic [RAD_W-1:0]    root_rad;
    logic                root_done;
    logic [DIST_W-1:0]   root_val;

    // table entry fields and hop arithmetic
    logic [CB-1:0]       cur_x;
    logic [CB-1:0]       cur_y;
    logic [CB-1:0]       dx;
    logic [CB-1:0]       dy;
    logic [SQ_W-1:0]     sq_sum;
    logic [TOUR_W:0]     tour_sum;
    logic [TOUR_W-1:0]   n_tour;
    logic [LOAD_W-1:0]   demand_ext;
    logic                at_depot;

    assign in_take = i_valid && !o_stall;
    assign emit_ok = !r_out_valid || !i_stall;
    assign o_stall = (r_state != S_IDLE);

    assign cur_x = r_rd_data[ENTRY_W-1 -: CB];
    assign cur_y = r_rd_data[ENTRY_W-CB-1 -: CB];
    assign dx    = (cur_x >= r_prev_x) ? (cur_x - r_prev_x) : (r_prev_x - cur_x);
    assign dy    = (cur_y >= r_prev_y) ? (cur_y - r_prev_y) : (r_prev_y - cur_y);

    assign sq_sum   = SQ_W'(r_sq) + SQ_W'(mul_prod[2*CB-1:0]);
    assign root_rad = RAD_W'(sq_sum);

    assign tour_sum   = {1'b0, r_tour} + (TOUR_W + 1)'(r_dist);
    assign n_tour     = tour_sum[TOUR_W] ? {TOUR_W{1'b1}} : tour_sum[TOUR_W-1:0];
    assign demand_ext = LOAD_W'(r_cur_demand);
    assign at_depot   = (r_node == r_depot);

    // units
    rfc_slot_reduce #(
        .NODE_COUNT (NODE_COUNT)
    ) u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_take),
        .i_node  (i_node_index),
        .o_done  (slot_done),
        .o_slot  (slot_val)
    );

    rfc_serial_mult #(
        .A_W (DIST_W),
        .B_W (MB_W)
    ) u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    rfc_serial_root #(
        .PAIRS (COORD_BITS + 1),
        .FRAC  (FRACTION_BITS)
    ) u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (root_rad),
        .o_done     (root_done),
        .o_root     (root_val)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and unit starts
    always_comb begin
        n_state    = r_state;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        root_start = 1'b0;
        rd_addr    = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                if (slot_done) begin
                    priority if (r_op == OP_LOAD) begin
                        n_state = S_WRITE;
                    end else if (r_start) begin
                        n_state = S_RESTART;
                    end else begin
                        n_state = S_RD_PREV;
                    end
                end
            end
            S_WRITE: begin
                n_state = S_EMIT;
            end
            S_RESTART: begin
                n_state = S_EMIT;
            end
            S_RD_PREV: begin
                rd_addr = r_prev_slot;
                n_state = S_RD_CUR;
            end
            S_RD_CUR: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                mul_start = 1'b1;
                mul_a     = DIST_W'(dx);
                mul_b     = MB_W'(dx);
                n_state   = S_SQ_X;
            end
            S_SQ_X: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = DIST_W'(r_dy);
                    mul_b     = MB_W'(r_dy);
                    n_state   = S_SQ_Y;
                end
            end
            S_SQ_Y: begin
                if (mul_done) begin
                    root_start = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                if (root_done) begin
                    mul_start = 1'b1;
                    mul_a     = root_val;
                    mul_b     = MB_W'(r_rate);
                    n_state   = S_ENERGY;
                end
            end
            S_ENERGY: begin
                if (mul_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cap <= '0;
            r_batt_cap <= '0;
            r_rate     <= RATE_RESET;
            r_depot    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOAD_CAPACITY:    r_load_cap <= i_cfg_data;
                CFG_BATTERY_CAPACITY: r_batt_cap <= i_cfg_data;
                CFG_CONSUMPTION_RATE: r_rate     <= i_cfg_data;
                CFG_DEPOT_NODE:       r_depot    <= i_cfg_data[NODE_W-1:0];
            endcase
        end
    end

    // item capture and hop working registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op         <= i_operation;
            r_node       <= i_node_index;
            r_x          <= CB'(i_coord_x);
            r_y          <= CB'(i_coord_y);
            r_demand_in  <= i_node_demand;
            r_station_in <= i_station_flag;
            r_start      <= i_route_start;
            r_end        <= i_route_end;
        end
        if (r_state == S_SLOT && slot_done) begin
            r_slot <= slot_val;
        end
        if (r_state == S_RD_CUR) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
        end
        if (r_state == S_DIFF) begin
            r_dy          <= dy;
            r_cur_demand  <= r_rd_data[DEMAND_W:1];
            r_cur_station <= r_rd_data[0];
        end
        if (r_state == S_SQ_X && mul_done) begin
            r_sq <= mul_prod[2*CB-1:0];
        end
        if (r_state == S_ROOT && root_done) begin
            r_dist <= root_val;
        end
        if (r_state == S_ENERGY && mul_done) begin
            r_used <= mul_prod[PROD_W-1:RATE_FRAC];
        end
    end

    // node table
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_table[r_slot] <= {r_x, r_y, r_demand_in, r_station_in};
        end
        r_rd_data <= r_table[rd_addr];
    end

    // route state: restart, hop update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_slot <= '0;
            r_load      <= '0;
            r_energy    <= '0;
            r_tour      <= '0;
            r_err       <= ST_OK;
            r_err_node  <= '0;
        end else if (r_state == S_RESTART) begin
            r_prev_slot <= r_slot;
            r_load      <= LOAD_W'(r_load_cap);
            r_energy    <= ENERGY_W'(r_batt_cap) << FRACTION_BITS;
            r_tour      <= '0;
            r_err       <= ST_OK;
            r_err_node  <= '0;
        end else if (r_state == S_UPDATE) begin
            r_prev_slot <= r_slot;
            r_tour      <= n_tour;
            if (r_err == ST_OK) begin
                priority if (demand_ext > r_load) begin
                    r_err      <= ST_LOAD;
                    r_err_node <= r_node;
                end else if (r_used > USED_W'(r_energy)) begin
                    r_err      <= ST_ENERGY;
                    r_err_node <= r_node;
                end else begin
                    // depot restores load, depot or station restores energy
                    r_load   <= at_depot ? LOAD_W'(r_load_cap) : (r_load - demand_ext);
                    r_energy <= (at_depot || r_cur_station)
                                ? (ENERGY_W'(r_batt_cap) << FRACTION_BITS)
                                : (r_energy - ENERGY_W'(r_used));
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && emit_ok) begin
            r_out_status <= r_err;
            r_out_tour   <= r_tour;
            r_out_fault  <= r_err_node;
            r_out_done   <= (r_op == OP_ROUTE) && r_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_route_length = r_out_tour;
    assign o_fault_node   = r_out_fault;
    assign o_route_done   = r_out_done;

    // checks
    `RFC_ASSERT_NOW(a_fault_clear_when_ok, (o_valid && o_status == ST_OK), (o_fault_node == '0), "fault node set with ok status")
    `RFC_ASSERT_NOW(a_status_code, o_valid, (o_status == ST_OK || o_status == ST_LOAD || o_status == ST_ENERGY), "undefined status code")
    `RFC_ASSERT_NEXT(a_item_starts_work, in_take, (r_state == S_SLOT), "accepted item did not start")
    `RFC_ASSERT_NEXT(a_error_sticky, (r_err != ST_OK && r_state != S_RESTART), (r_err == $past(r_err)), "error status changed without restart")

endmodule

`default_nettype wire

// File: tb/sv/route_feasibility_checker_chk.sv
`timescale 1ns / 1ps

module route_feasibility_checker_chk #(
    parameter int NODE_COUNT    = 256,
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item side
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_operation,
    input  logic [rfc_pkg::NODE_W-1:0]     i_node_index,
    input  logic [rfc_pkg::IN_COORD_W-1:0] i_coord_x,
    input  logic [rfc_pkg::IN_COORD_W-1:0] i_coord_y,
    input  logic [rfc_pkg::DEMAND_W-1:0]   i_node_demand,
    input  logic                           i_station_flag,
    input  logic                           i_route_start,
    input  logic                           i_route_end,
    // result side
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [rfc_pkg::STATUS_W-1:0]   i_status,
    input  logic [rfc_pkg::TOUR_W-1:0]     i_route_length,
    input  logic [rfc_pkg::NODE_W-1:0]     i_fault_node,
    input  logic                           i_route_done,
    // register writes
    input  logic                           i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]      i_cfg_data,
    // totals for the top
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import rfc_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOUR_W-1:0]   tour;
        logic [NODE_W-1:0]   fault;
        logic                done;
    } t_trip_report;

    localparam logic [63:0] TOUR_CEIL  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS) - 64'd1;

    // node table copy
    logic [31:0]         node_x       [NODE_COUNT];
    logic [31:0]         node_y       [NODE_COUNT];
    logic [DEMAND_W-1:0] node_need    [NODE_COUNT];
    logic                node_charger [NODE_COUNT];

    // register copy
    logic [CFG_W-1:0]  load_cap;
    logic [CFG_W-1:0]  battery_cap;
    logic [CFG_W-1:0]  rate;
    logic [NODE_W-1:0] depot;

    // route progress
    logic [NODE_W-1:0]   last_node;
    logic [LOAD_W-1:0]   load_left;
    logic [63:0]         energy_left;
    logic [63:0]         tour_acc;
    logic [STATUS_W-1:0] trip_status;
    logic [NODE_W-1:0]   trip_fault;

    t_trip_report trip_reports[$];
    int           mismatches = 0;
    int           compared   = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = compared;

    // floor of sqrt(sq) scaled by 2^FRACTION_BITS
    function automatic logic [63:0] fixed_root(input logic [63:0] sq);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = sq << (2 * FRACTION_BITS);
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // advance the copy of the block by one item and form its result
    task automatic walk_item(input logic op, input logic [NODE_W-1:0] node,
                             input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                             input logic [DEMAND_W-1:0] need, input logic charger,
                             input logic start, input logic last,
                             output t_trip_report rep);
        int          from;
        int          slot;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] hop_len;
        logic [63:0] used;
        slot = node % NODE_COUNT;
        if (op == OP_LOAD) begin
            node_x[slot]       = 32'(x & COORD_MASK);
            node_y[slot]       = 32'(y & COORD_MASK);
            node_need[slot]    = need;
            node_charger[slot] = charger;
        end else if (start) begin
            load_left   = LOAD_W'(load_cap);
            energy_left = 64'(battery_cap) << FRACTION_BITS;
            tour_acc    = 64'd0;
            trip_status = ST_OK;
            trip_fault  = '0;
            last_node   = node;
        end else begin
            from = last_node % NODE_COUNT;
            dx   = (node_x[from] >= node_x[slot]) ? 64'(node_x[from] - node_x[slot])
                                                  : 64'(node_x[slot] - node_x[from]);
            dy   = (node_y[from] >= node_y[slot]) ? 64'(node_y[from] - node_y[slot])
                                                  : 64'(node_y[slot] - node_y[from]);
            hop_len  = fixed_root(dx * dx + dy * dy);
            tour_acc = tour_acc + hop_len;
            if (tour_acc > TOUR_CEIL) tour_acc = TOUR_CEIL;
            // checks only until the first violation, which freezes load and energy
            if (trip_status == ST_OK) begin
                used = (64'(rate) * hop_len) >> RATE_FRAC;
                if (18'(node_need[slot]) > load_left) begin
                    trip_status = ST_LOAD;
                    trip_fault  = node;
                end else if (used > energy_left) begin
                    trip_status = ST_ENERGY;
                    trip_fault  = node;
                end else begin
                    load_left   = load_left - 18'(node_need[slot]);
                    energy_left = energy_left - used;
                    if (node == depot) load_left = LOAD_W'(load_cap);
                    if (node == depot || node_charger[slot])
                        energy_left = 64'(battery_cap) << FRACTION_BITS;
                end
            end
            last_node = node;
        end
        rep.status = trip_status;
        rep.tour   = tour_acc[TOUR_W-1:0];
        rep.fault  = trip_fault;
        rep.done   = (op == OP_ROUTE) ? last : 1'b0;
    endtask

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin : watch
        t_trip_report fresh;
        t_trip_report oldest;
        if (!i_rst_n) begin
            load_cap    = '0;
            battery_cap = '0;
            rate        = RATE_RESET;
            depot       = '0;
            last_node   = '0;
            load_left   = '0;
            energy_left = 64'd0;
            tour_acc    = 64'd0;
            trip_status = ST_OK;
            trip_fault  = '0;
            trip_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOAD_CAPACITY:    load_cap    = i_cfg_data;
                    CFG_BATTERY_CAPACITY: battery_cap = i_cfg_data;
                    CFG_CONSUMPTION_RATE: rate        = i_cfg_data;
                    CFG_DEPOT_NODE:       depot       = i_cfg_data[NODE_W-1:0];
                    default: ;
                endcase
            end
            // compare before queuing: a result never belongs to an item taken this edge
            if (i_out_valid && !i_out_stall) begin
                if (trip_reports.size() == 0) begin
                    $error("result with no item outstanding: status %0d length %0d",
                           i_status, i_route_length);
                    mismatches++;
                end else begin
                    oldest = trip_reports.pop_front();
                    flag_field("status", 64'(oldest.status), 64'(i_status));
                    flag_field("route_length", 64'(oldest.tour), 64'(i_route_length));
                    flag_field("fault_node", 64'(oldest.fault), 64'(i_fault_node));
                    flag_field("route_done", 64'(oldest.done), 64'(i_route_done));
                    compared++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                walk_item(i_operation, i_node_index, i_coord_x, i_coord_y, i_node_demand,
                          i_station_flag, i_route_start, i_route_end, fresh);
                trip_reports.insert(trip_reports.size(), fresh);
            end
        end
        o_pending <= trip_reports.size();
    end

endmodule

// File: tb/sv/route_feasibility_checker_tb.sv
`timescale 1ns / 1ps

module route_feasibility_checker_tb;
    import rfc_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // item side
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  op           = OP_LOAD;
    logic [NODE_W-1:0]     node_index   = '0;
    logic [IN_COORD_W-1:0] coord_x      = '0;
    logic [IN_COORD_W-1:0] coord_y      = '0;
    logic [DEMAND_W-1:0]   node_demand  = '0;
    logic                  station_flag = 1'b0;
    logic                  route_start  = 1'b0;
    logic                  route_end    = 1'b0;

    // result side
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [TOUR_W-1:0]     route_length;
    logic [NODE_W-1:0]     fault_node;
    logic                  route_done;

    // register port
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOAD_CAPACITY;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;

    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned routes_begun  = 0;
    int unsigned phases_run    = 0;
    int unsigned quiet_cycles  = 0;
    logic [NODE_W-1:0] depot_sel = '0;
    logic [NODE_W-1:0] known_nodes[$];
    logic [NODE_W-1:0] phase_nodes[$];

    always #10 clk = ~clk;

    route_feasibility_checker dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_operation    (op),
        .i_node_index   (node_index),
        .i_coord_x      (coord_x),
        .i_coord_y      (coord_y),
        .i_node_demand  (node_demand),
        .i_station_flag (station_flag),
        .i_route_start  (route_start),
        .i_route_end    (route_end),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_status       (status),
        .o_route_length (route_length),
        .o_fault_node   (fault_node),
        .o_route_done   (route_done),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    route_feasibility_checker_chk chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (op),
        .i_node_index   (node_index),
        .i_coord_x      (coord_x),
        .i_coord_y      (coord_y),
        .i_node_demand  (node_demand),
        .i_station_flag (station_flag),
        .i_route_start  (route_start),
        .i_route_end    (route_end),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_route_length (route_length),
        .i_fault_node   (fault_node),
        .i_route_done   (route_done),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // watchdog on cycles where neither channel moves
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL route_feasibility_checker");
                $finish;
            end
        end
    end

    // result consumer with random stalls and one long hold on request
    initial begin : sink
        int unsigned pause;
        wait (rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            pause = idle_on ? $urandom_range(0, 6) : 0;
            if (pause != 0) begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one item and hold it until taken
    task automatic send_item(input logic kind, input logic [NODE_W-1:0] nd,
                             input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                             input logic [DEMAND_W-1:0] need, input logic charger,
                             input logic start, input logic last);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op           <= kind;
        node_index   <= nd;
        coord_x      <= x;
        coord_y      <= y;
        node_demand  <= need;
        station_flag <= charger;
        route_start  <= start;
        route_end    <= last;
        in_valid     <= 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic load_node(input logic [NODE_W-1:0] nd, input logic [IN_COORD_W-1:0] x,
                             input logic [IN_COORD_W-1:0] y, input logic [DEMAND_W-1:0] need,
                             input logic charger);
        send_item(OP_LOAD, nd, x, y, need, charger, 1'($urandom), 1'($urandom));
        known_nodes.insert(known_nodes.size(), nd);
        phase_nodes.insert(phase_nodes.size(), nd);
    endtask

    task automatic route_step(input logic [NODE_W-1:0] nd, input logic start,
                              input logic last);
        send_item(OP_ROUTE, nd, IN_COORD_W'($urandom), IN_COORD_W'($urandom),
                  DEMAND_W'($urandom), 1'($urandom), start, last);
        if (start) routes_begun++;
    endtask

    // all four registers back to back, write enable held high
    task automatic write_regs(input logic [CFG_W-1:0] lc, input logic [CFG_W-1:0] bc,
                              input logic [CFG_W-1:0] cr, input logic [NODE_W-1:0] dp);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOAD_CAPACITY;
        cfg_data  <= lc;
        @(posedge clk);
        cfg_index <= CFG_BATTERY_CAPACITY;
        cfg_data  <= bc;
        @(posedge clk);
        cfg_index <= CFG_CONSUMPTION_RATE;
        cfg_data  <= cr;
        @(posedge clk);
        cfg_index <= CFG_DEPOT_NODE;
        cfg_data  <= {8'h00, dp};
        @(posedge clk);
        cfg_we    <= 1'b0;
        depot_sel  = dp;
    endtask

    // sender stops until every result is back and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // next stop: mostly this phase's nodes, sometimes the depot or any loaded node
    function automatic logic [NODE_W-1:0] pick_stop();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 3) return depot_sel;
        if (r == 3) return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
        return phase_nodes[$urandom_range(0, phase_nodes.size() - 1)];
    endfunction

    function automatic logic [DEMAND_W-1:0] pick_need(input logic [CFG_W-1:0] lc);
        if ($urandom_range(0, 7) == 0) return DEMAND_W'($urandom);
        return DEMAND_W'($urandom_range(0, lc / 4));
    endfunction

    task automatic run_phase(input logic [CFG_W-1:0] lc, input logic [CFG_W-1:0] bc,
                             input logic [CFG_W-1:0] cr, input logic [NODE_W-1:0] dp,
                             input logic [IN_COORD_W-1:0] cmask, input int unsigned budget,
                             input bit idling, input bit hold);
        int unsigned first;
        int unsigned kind;
        int unsigned hops;
        settle();
        idle_on = idling;
        write_regs(lc, bc, cr, dp);
        phase_nodes.delete();
        first = items_sent;
        // fresh batch of nodes at this phase's coordinate scale, depot first
        load_node(dp, IN_COORD_W'($urandom & cmask), IN_COORD_W'($urandom & cmask), '0,
                  1'($urandom));
        repeat (11) load_node(NODE_W'($urandom), IN_COORD_W'($urandom & cmask),
                              IN_COORD_W'($urandom & cmask), pick_need(lc),
                              $urandom_range(0, 3) == 0);
        if (hold) long_hold_req = 1'b1;
        while (items_sent - first < budget) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                load_node(NODE_W'($urandom), IN_COORD_W'($urandom & cmask),
                          IN_COORD_W'($urandom & cmask), pick_need(lc),
                          $urandom_range(0, 3) == 0);
            end else if (kind == 1) begin
                // stray hop with no start
                route_step(pick_stop(), 1'b0, $urandom_range(0, 3) == 0);
            end else begin
                route_step(($urandom_range(0, 3) == 0) ? pick_stop() : dp, 1'b1, 1'b0);
                hops = $urandom_range(1, 8);
                repeat (hops - 1) route_step(pick_stop(), 1'b0, 1'b0);
                route_step(pick_stop(), 1'b0, $urandom_range(0, 7) != 0);
            end
        end
        phases_run++;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes, stations, both violations, frozen state
        write_regs(16'd1000, 16'd500, RATE_RESET, 8'd0);
        load_node(8'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        load_node(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        load_node(8'd1, 16'd3, 16'd4, 16'd10, 1'b0);
        load_node(8'd2, 16'hFFFF, 16'd0, 16'd0, 1'b1);
        load_node(8'd170, 16'd6, 16'd8, 16'd20, 1'b0);
        load_node(8'd85, 16'd0, 16'hFFFF, 16'd0, 1'b1);
        load_node(8'd3, 16'd0, 16'd10, 16'd5, 1'b1);
        // short hops, back to depot, then load and energy both short on one hop
        route_step(8'd0, 1'b1, 1'b0);
        route_step(8'd1, 1'b0, 1'b0);
        route_step(8'd170, 1'b0, 1'b0);
        route_step(8'd0, 1'b0, 1'b0);
        route_step(8'd255, 1'b0, 1'b0);
        route_step(8'd1, 1'b0, 1'b1);
        // hop after the end without a new start
        route_step(8'd0, 1'b0, 1'b0);
        // energy runs out on a long hop
        route_step(8'd0, 1'b1, 1'b0);
        route_step(8'd2, 1'b0, 1'b1);
        // station recharge and a zero-length hop
        route_step(8'd0, 1'b1, 1'b0);
        route_step(8'd3, 1'b0, 1'b0);
        route_step(8'd1, 1'b0, 1'b0);
        route_step(8'd1, 1'b0, 1'b1);
        // start and end on the same item
        route_step(8'd0, 1'b1, 1'b1);

        // random phases over several register settings
        run_phase(16'd1000, 16'd2000, RATE_RESET, NODE_W'($urandom), 16'h00FF, 100,
                  1'b1, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0, 16'h00FF, 90, 1'b0, 1'b1);
        run_phase(16'd0, 16'd0, 16'd0, 8'd255, 16'hFFFF, 80, 1'b1, 1'b0);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 1024)),
                  NODE_W'($urandom), 16'h0FFF, 110, 1'b1, 1'b0);
        run_phase(16'd500, 16'hFFFF, 16'd16, NODE_W'($urandom), 16'hFFFF, 90, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), NODE_W'($urandom),
                  16'h03FF, 110, 1'b1, 1'b1);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);

        $display("run: %0d items (%0d routes begun) over %0d register settings plus directed",
                 items_sent, routes_begun, phases_run);
        $display("run: %0d results compared field by field", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS route_feasibility_checker");
        end else begin
            if (pending != 0) $error("%0d results never arrived", pending);
            $display("FAIL route_feasibility_checker");
        end
        $finish;
    end

endmodule
